### rtl/ecg_beat_detector_bpm_defines.svh
// Assertion macros used by the checker file of the beat detector.
`ifndef ECG_BEAT_DETECTOR_BPM_DEFINES_SVH
`define ECG_BEAT_DETECTOR_BPM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECGBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECGBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ecgbd_pkg.sv
`default_nettype none

package ecgbd_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 48;
    localparam int BPM_W    = 10;
    localparam int RISE_W   = 8;
    localparam int HOLD_W   = 4;
    localparam int AVG_W    = 32;
    localparam int COEF_W   = 16;
    localparam int CNT_W    = 4;
    // Accumulator of the shift-add multiplier, with headroom for the signed sums.
    localparam int ACC_W    = 50;

    localparam int HISTORY_DEPTH_DEF = 30;

    // Filter coefficients in Q0.16.
    localparam logic [COEF_W-1:0] SLOW_KEEP = 16'd63570;
    localparam logic [COEF_W-1:0] SLOW_TAKE = 16'd1966;
    localparam logic [COEF_W-1:0] FAST_KEEP = 16'd58982;
    localparam logic [COEF_W-1:0] FAST_TAKE = 16'd6554;
    localparam logic [COEF_W-1:0] PEAK_KEEP = 16'd65503;
    localparam logic [CNT_W-1:0]  CNT_LAST  = 4'(COEF_W - 1);
    localparam logic [ACC_W-1:0]  ROUND_BIAS = 50'd32768;

    // Rate computation constants.
    localparam longint unsigned US_PER_MIN  = 64'd60000000;
    localparam longint unsigned MIN_SPAN_US = 64'd200000;

    // Register file.
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RISE_LENGTH    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLDOFF_LENGTH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BPM_LOW        = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BPM_HIGH       = 2'd3;

    localparam logic [RISE_W-1:0] RISE_LENGTH_RST    = 8'd15;
    localparam logic [HOLD_W-1:0] HOLDOFF_LENGTH_RST = 4'd10;
    localparam logic [BPM_W-1:0]  BPM_LOW_RST        = 10'd30;
    localparam logic [BPM_W-1:0]  BPM_HIGH_RST       = 10'd300;

    // Numerator of the rate division: beats in the history times one minute.
    function automatic longint unsigned rate_numerator(input int depth);
        rate_numerator = longint'(depth - 1) * US_PER_MIN;
    endfunction

    // Bits needed for the largest rate, reached at the minimum span.
    function automatic int quot_width(input int depth);
        longint unsigned qmax;
        qmax = rate_numerator(depth) / MIN_SPAN_US;
        quot_width = $clog2(qmax + 1);
    endfunction

endpackage

`default_nettype wire

### rtl/ecgbd_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle of the fixed rate numerator
// by the beat span.
module ecgbd_div
    import ecgbd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [TIME_W-1:0]                     span,
    output logic                                       busy,
    output logic [quot_width(HISTORY_DEPTH)-1:0]       quotient
);

    localparam longint unsigned NUM = rate_numerator(HISTORY_DEPTH);
    localparam int NW   = $clog2(NUM + 1);
    localparam int QW   = quot_width(HISTORY_DEPTH);
    localparam int DW   = NW + QW;
    localparam int CNTW = $clog2(QW + 1);

    logic              busy_reg, busy_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     dv_reg, dv_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [DW:0]       trial;

    // Trial subtraction of the shifted divisor from the remainder.
    assign trial = {1'b0, {QW{1'b0}}, rem_reg} - {1'b0, dv_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        if (start)
        begin
            q_next   = '0;
            rem_next = NW'(NUM);
            dv_next  = {span[NW-1:0], {(QW-1){1'b0}}, 1'b0} >> 1;
            cnt_next = CNTW'(QW);
            // A span wider than the numerator always gives a zero rate.
            busy_next = (span[TIME_W-1:NW] == '0);
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial[NW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            dv_next  = dv_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### rtl/ecg_beat_detector_bpm.sv
// ECG beat detector with heart-rate estimate.
// Sample channel: sample and time_us are taken at a clock edge with
// sample_valid high and sample_stall low. Result channel: beat and bpm are
// offered with result_valid and move on an edge where result_stall is low.
// Every sample gives exactly one result.
// An accepted sample runs through two 16-step shift-add multiplications
// (filter update, then peak decay) that share the slow-filter accumulator;
// the serial rate divider runs alongside the peak decay. The result is
// registered before the block takes the next sample, so it works on one
// sample at a time.
// A finished result sits in an output register, so the next sample is taken
// while the receiver stalls; only when a second result is ready and the
// register is still full does the block hold and keep sample_stall high.
// Reset clears the filters, the peak level, the counters and the beat history,
// and loads the register defaults. Configuration is written over the APB port
// at byte addresses 0, 4, 8 and 12, only while idle: a user rule, unenforced.
`default_nettype none

module ecg_beat_detector_bpm
    import ecgbd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Sample channel.
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [TIME_W-1:0]          time_us,
    // Result channel.
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic                            beat,
    output logic [BPM_W-1:0]                bpm,
    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]               prdata,
    output logic                            pready
);

    localparam int QW   = quot_width(HISTORY_DEPTH);
    localparam int CW   = (QW > BPM_W) ? QW : BPM_W;
    localparam int OLD  = HISTORY_DEPTH - 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_PEAK = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // Saturate an accumulator shifted down by 16 to the signed 32-bit range.
    function automatic logic [AVG_W-1:0] sat_avg(input logic [ACC_W-1:0] a);
        logic ovf;
        ovf = (a[ACC_W-1:AVG_W+15] != {(ACC_W-AVG_W-15){a[ACC_W-1]}});
        if (ovf)
        begin
            sat_avg = a[ACC_W-1] ? {1'b1, {(AVG_W-1){1'b0}}} : {1'b0, {(AVG_W-1){1'b1}}};
        end
        else
        begin
            sat_avg = a[AVG_W+15:16];
        end
    endfunction

    // Control state.
    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    fire_reg, fire_next;
    logic                    out_valid_reg, out_valid_next;

    // Filter and detector state.
    logic [AVG_W-1:0]        slow_reg, slow_next;
    logic [AVG_W-1:0]        fast_reg, fast_next;
    logic [AVG_W-1:0]        peak_reg, peak_next;
    logic [RISE_W-1:0]       run_reg, run_next;
    logic [HOLD_W-1:0]       hold_reg, hold_next;
    logic [TIME_W-1:0]       hist_reg [0:HISTORY_DEPTH-2];
    logic [TIME_W-1:0]       hist_next [0:HISTORY_DEPTH-2];

    // Configuration registers.
    logic [RISE_W-1:0]       rise_length_reg, rise_length_next;
    logic [HOLD_W-1:0]       holdoff_length_reg, holdoff_length_next;
    logic [BPM_W-1:0]        bpm_low_reg, bpm_low_next;
    logic [BPM_W-1:0]        bpm_high_reg, bpm_high_next;

    // Datapath registers.
    logic [TIME_W-1:0]       t_reg, t_next;
    logic [ACC_W-1:0]        acc_s_reg, acc_s_next;
    logic [ACC_W-1:0]        acc_f_reg, acc_f_next;
    logic [ACC_W-1:0]        ma_s_reg, ma_s_next;
    logic [ACC_W-1:0]        ma_f_reg, ma_f_next;
    logic [ACC_W-1:0]        mx_reg, mx_next;
    logic [AVG_W-1:0]        cc_reg, cc_next;
    logic [TIME_W-1:0]       span_raw_reg, span_raw_next;
    logic                    span_neg_reg, span_neg_next;
    logic [TIME_W-1:0]       span_reg, span_next;
    logic                    out_beat_reg, out_beat_next;
    logic [BPM_W-1:0]        out_bpm_reg, out_bpm_next;

    // Combinational helpers.
    logic [ACC_W-1:0]        acc_s_sum, acc_f_sum;
    logic                    keep_s_bit;
    logic [AVG_W:0]          d_fs, d_sf;
    logic [TIME_W:0]         d_span;
    logic [RISE_W-1:0]       run_new;
    logic                    qualify;
    logic [AVG_W-1:0]        peak_pre;
    logic [HOLD_W-1:0]       hold_pre;
    logic                    cfg_wr;
    logic                    out_free;
    logic                    div_start;
    logic                    div_busy;
    logic [QW-1:0]           quot;
    logic [CW-1:0]           q_ext;
    logic                    in_band;

    // Shared shift-add step: one coefficient bit per cycle.
    assign keep_s_bit = (state_reg == S_PEAK) ? PEAK_KEEP[cnt_reg] : SLOW_KEEP[cnt_reg];
    assign acc_s_sum = acc_s_reg + (keep_s_bit ? ma_s_reg : '0)
                     + (((state_reg == S_MAC) && SLOW_TAKE[cnt_reg]) ? mx_reg : '0);
    assign acc_f_sum = acc_f_reg + (FAST_KEEP[cnt_reg] ? ma_f_reg : '0)
                     + (FAST_TAKE[cnt_reg] ? mx_reg : '0);

    // Both orders of the average difference, so the magnitude is a select.
    assign d_fs   = {fast_reg[AVG_W-1], fast_reg} - {slow_reg[AVG_W-1], slow_reg};
    assign d_sf   = {slow_reg[AVG_W-1], slow_reg} - {fast_reg[AVG_W-1], fast_reg};
    assign d_span = {1'b0, t_reg} - {1'b0, hist_reg[OLD]};

    // Rise run and peak qualification.
    always_comb
    begin
        if (cc_reg > peak_reg)
        begin
            run_new = (run_reg == {RISE_W{1'b1}}) ? run_reg : run_reg + 1'b1;
        end
        else
        begin
            run_new = '0;
        end
        qualify  = (run_new > rise_length_reg);
        peak_pre = qualify ? cc_reg : peak_reg;
        hold_pre = qualify ? holdoff_length_reg : hold_reg;
    end

    // Band check of the rate.
    assign q_ext   = CW'(quot);
    assign in_band = (q_ext >= CW'(bpm_low_reg)) && (q_ext <= CW'(bpm_high_reg));

    assign cfg_wr    = psel && penable && pwrite;
    assign out_free  = !out_valid_reg || !result_stall;
    assign div_start = (state_reg == S_PEAK) && (cnt_reg == '0) && fire_reg;

    always_comb
    begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        fire_next           = fire_reg;
        slow_next           = slow_reg;
        fast_next           = fast_reg;
        peak_next           = peak_reg;
        run_next            = run_reg;
        hold_next           = hold_reg;
        hist_next           = hist_reg;
        rise_length_next    = rise_length_reg;
        holdoff_length_next = holdoff_length_reg;
        bpm_low_next        = bpm_low_reg;
        bpm_high_next       = bpm_high_reg;
        t_next              = t_reg;
        acc_s_next          = acc_s_reg;
        acc_f_next          = acc_f_reg;
        ma_s_next           = ma_s_reg;
        ma_f_next           = ma_f_reg;
        mx_next             = mx_reg;
        cc_next             = cc_reg;
        span_raw_next       = span_raw_reg;
        span_neg_next       = span_neg_reg;
        span_next           = span_reg;
        out_beat_next       = out_beat_reg;
        out_bpm_next        = out_bpm_reg;
        out_valid_next      = out_valid_reg;

        // The waiting result leaves on a transfer.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    t_next     = time_us;
                    acc_s_next = ROUND_BIAS;
                    acc_f_next = ROUND_BIAS;
                    ma_s_next  = {{(ACC_W-AVG_W){slow_reg[AVG_W-1]}}, slow_reg};
                    ma_f_next  = {{(ACC_W-AVG_W){fast_reg[AVG_W-1]}}, fast_reg};
                    mx_next    = {{(ACC_W-SAMPLE_W-16){sample[SAMPLE_W-1]}}, sample, 16'd0};
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                acc_s_next = acc_s_sum;
                acc_f_next = acc_f_sum;
                ma_s_next  = ma_s_reg << 1;
                ma_f_next  = ma_f_reg << 1;
                mx_next    = mx_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                slow_next  = sat_avg(acc_s_reg);
                fast_next  = sat_avg(acc_f_reg);
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cc_next       = d_fs[AVG_W] ? d_sf[AVG_W-1:0] : d_fs[AVG_W-1:0];
                span_raw_next = d_span[TIME_W-1:0];
                span_neg_next = d_span[TIME_W];
                state_next    = S_CMP;
            end
            S_CMP:
            begin
                run_next  = run_new;
                fire_next = qualify && (hold_reg == '0);
                hold_next = (hold_pre != '0) ? hold_pre - 1'b1 : hold_pre;
                if (span_neg_reg || (span_raw_reg < TIME_W'(MIN_SPAN_US)))
                begin
                    span_next = TIME_W'(MIN_SPAN_US);
                end
                else
                begin
                    span_next = span_raw_reg;
                end
                // A beat pushes its time into the history.
                if (qualify && (hold_reg == '0))
                begin
                    for (int i = HISTORY_DEPTH - 2; i > 0; i--)
                    begin
                        hist_next[i] = hist_reg[i-1];
                    end
                    hist_next[0] = t_reg;
                end
                acc_s_next = ROUND_BIAS;
                ma_s_next  = {{(ACC_W-AVG_W){1'b0}}, peak_pre};
                cnt_next   = '0;
                state_next = S_PEAK;
            end
            S_PEAK:
            begin
                acc_s_next = acc_s_sum;
                ma_s_next  = ma_s_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    peak_next  = acc_s_sum[AVG_W+15:16];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!div_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_beat_next  = fire_reg;
                    out_bpm_next   = (fire_reg && in_band) ? q_ext[BPM_W-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Register writes from the configuration port.
        if (cfg_wr)
        begin
            case (paddr[ADDR_W-1:2])
                REG_RISE_LENGTH:    rise_length_next    = pwdata[RISE_W-1:0];
                REG_HOLDOFF_LENGTH: holdoff_length_next = pwdata[HOLD_W-1:0];
                REG_BPM_LOW:        bpm_low_next        = pwdata[BPM_W-1:0];
                REG_BPM_HIGH:       bpm_high_next       = pwdata[BPM_W-1:0];
                default:            rise_length_next    = rise_length_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_RISE_LENGTH:    prdata = DATA_W'(rise_length_reg);
            REG_HOLDOFF_LENGTH: prdata = DATA_W'(holdoff_length_reg);
            REG_BPM_LOW:        prdata = DATA_W'(bpm_low_reg);
            REG_BPM_HIGH:       prdata = DATA_W'(bpm_high_reg);
            default:            prdata = '0;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cnt_reg            <= '0;
            fire_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
            slow_reg           <= '0;
            fast_reg           <= '0;
            peak_reg           <= '0;
            run_reg            <= '0;
            hold_reg           <= '0;
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            begin
                hist_reg[i] <= '0;
            end
            rise_length_reg    <= RISE_LENGTH_RST;
            holdoff_length_reg <= HOLDOFF_LENGTH_RST;
            bpm_low_reg        <= BPM_LOW_RST;
            bpm_high_reg       <= BPM_HIGH_RST;
        end
        else
        begin
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            fire_reg           <= fire_next;
            out_valid_reg      <= out_valid_next;
            slow_reg           <= slow_next;
            fast_reg           <= fast_next;
            peak_reg           <= peak_next;
            run_reg            <= run_next;
            hold_reg           <= hold_next;
            hist_reg           <= hist_next;
            rise_length_reg    <= rise_length_next;
            holdoff_length_reg <= holdoff_length_next;
            bpm_low_reg        <= bpm_low_next;
            bpm_high_reg       <= bpm_high_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        acc_s_reg    <= acc_s_next;
        acc_f_reg    <= acc_f_next;
        ma_s_reg     <= ma_s_next;
        ma_f_reg     <= ma_f_next;
        mx_reg       <= mx_next;
        cc_reg       <= cc_next;
        span_raw_reg <= span_raw_next;
        span_neg_reg <= span_neg_next;
        span_reg     <= span_next;
        out_beat_reg <= out_beat_next;
        out_bpm_reg  <= out_bpm_next;
    end

    // Serial rate divider.
    ecgbd_div #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .span     (span_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign beat         = out_beat_reg;
    assign bpm          = out_bpm_reg;
    assign pready       = 1'b1;

endmodule

`default_nettype wire

### rtl/ecgbd_checker.sv
`default_nettype none

`include "ecg_beat_detector_bpm_defines.svh"

// Port-level checks of the beat detector.
module ecgbd_checker
    import ecgbd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             sample_valid,
    input wire logic             sample_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire logic             beat,
    input wire logic [BPM_W-1:0] bpm
);

    // A stalled result stays offered and unchanged.
    `ECGBD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(beat) && $stable(bpm), "stalled result changed")

    // A result without a beat carries no rate.
    `ECGBD_ASSERT_SAME(a_no_beat_zero, result_valid && !beat, bpm == '0, "rate reported without a beat")

    // The block works on one sample at a time.
    `ECGBD_ASSERT_NEXT(a_busy_after_take, sample_valid && !sample_stall, sample_stall, "sample taken while busy")

    // No result can appear in the cycle right after a sample transfer.
    `ECGBD_ASSERT_NEXT(a_no_instant_result, sample_valid && !sample_stall, !$rose(result_valid), "result too early")

endmodule

bind ecg_beat_detector_bpm ecgbd_checker u_checker (.*);

`default_nettype wire
